// ===== rtl/mutual_exclusion_request_engine_defines.svh =====
// assertion macros shared by the mutual exclusion request engine
`ifndef MUTUAL_EXCLUSION_REQUEST_ENGINE_DEFINES_SVH
`define MUTUAL_EXCLUSION_REQUEST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MERE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MERE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mere_pkg.sv =====
// types, codes and microcode table of the mutual exclusion request engine
package mere_pkg;

   localparam int ID_W        = 4;
   localparam int SLOTS       = 16;
   localparam int TIME_W      = 16;
   localparam int FUNC_W      = 3;
   localparam int KIND_W      = 2;
   localparam int UPC_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_NODES_DEF = 16;

   // input function codes
   localparam logic [FUNC_W-1:0] FUNC_START      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PEER_REQ   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEER_REPLY = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PEER_DONE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 3'd4;

   // outgoing message kinds
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MCAST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MY_NODE_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_MASK  = 1'b1;

   // microcode step addresses
   localparam logic [UPC_W-1:0] U_START    = 4'd0;
   localparam logic [UPC_W-1:0] U_STAMP    = 4'd1;
   localparam logic [UPC_W-1:0] U_MCAST    = 4'd2;
   localparam logic [UPC_W-1:0] U_PREQ     = 4'd3;
   localparam logic [UPC_W-1:0] U_PREQ_CMP = 4'd4;
   localparam logic [UPC_W-1:0] U_REPLY    = 4'd5;
   localparam logic [UPC_W-1:0] U_DEFER    = 4'd6;
   localparam logic [UPC_W-1:0] U_PREP     = 4'd7;
   localparam logic [UPC_W-1:0] U_MARK     = 4'd8;
   localparam logic [UPC_W-1:0] U_PDONE    = 4'd9;
   localparam logic [UPC_W-1:0] U_DROP     = 4'd10;
   localparam logic [UPC_W-1:0] U_REL      = 4'd11;
   localparam logic [UPC_W-1:0] U_REL_CHK  = 4'd12;
   localparam logic [UPC_W-1:0] U_WALK     = 4'd13;
   localparam logic [UPC_W-1:0] U_IDLE     = 4'd14;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SET_REQ,
      ACT_SET_DEFER,
      ACT_MARK_REPLY,
      ACT_DROP_PEER,
      ACT_CLR_REQ
   } act_type;

   typedef enum logic [2:0] {
      EM_OFF,
      EM_IDLE,
      EM_MCAST,
      EM_REPLY_SENDER,
      EM_REPLY_WALK
   } emit_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_REQUESTING,
      CND_BAD_SENDER,
      CND_DEFER,
      CND_DEF_EMPTY,
      CND_WALK_MORE
   } cond_type;

   typedef struct packed {
      act_type           act;
      emit_type          emit;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
      logic              fin;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      act_type  act;
      emit_type emit;
      logic     last;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic requesting;
      logic bad_sender;
      logic defer;
      logic def_empty;
      logic walk_more;
   } status_type;

   // one result transaction
   typedef struct packed {
      logic [KIND_W-1:0] send_kind;
      logic [ID_W-1:0]   dest_id;
      logic [TIME_W-1:0] send_time;
      logic              granted;
      logic              last;
   } item_type;

   // control store
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      unique case (addr)
         U_START:    w = '{ACT_NONE,       EM_OFF,          CND_REQUESTING, U_IDLE,    1'b0};
         U_STAMP:    w = '{ACT_SET_REQ,    EM_OFF,          CND_NEVER,      U_IDLE,    1'b0};
         U_MCAST:    w = '{ACT_NONE,       EM_MCAST,        CND_NEVER,      U_IDLE,    1'b1};
         U_PREQ:     w = '{ACT_NONE,       EM_OFF,          CND_BAD_SENDER, U_IDLE,    1'b0};
         U_PREQ_CMP: w = '{ACT_NONE,       EM_OFF,          CND_DEFER,      U_DEFER,   1'b0};
         U_REPLY:    w = '{ACT_NONE,       EM_REPLY_SENDER, CND_NEVER,      U_IDLE,    1'b1};
         U_DEFER:    w = '{ACT_SET_DEFER,  EM_OFF,          CND_ALWAYS,     U_IDLE,    1'b0};
         U_PREP:     w = '{ACT_NONE,       EM_OFF,          CND_BAD_SENDER, U_IDLE,    1'b0};
         U_MARK:     w = '{ACT_MARK_REPLY, EM_OFF,          CND_ALWAYS,     U_IDLE,    1'b0};
         U_PDONE:    w = '{ACT_NONE,       EM_OFF,          CND_BAD_SENDER, U_IDLE,    1'b0};
         U_DROP:     w = '{ACT_DROP_PEER,  EM_OFF,          CND_ALWAYS,     U_IDLE,    1'b0};
         U_REL:      w = '{ACT_CLR_REQ,    EM_OFF,          CND_NEVER,      U_IDLE,    1'b0};
         U_REL_CHK:  w = '{ACT_NONE,       EM_OFF,          CND_DEF_EMPTY,  U_IDLE,    1'b0};
         U_WALK:     w = '{ACT_NONE,       EM_REPLY_WALK,   CND_WALK_MORE,  U_WALK,    1'b1};
         U_IDLE:     w = '{ACT_NONE,       EM_IDLE,         CND_NEVER,      U_IDLE,    1'b1};
         default:    w = '{ACT_NONE,       EM_IDLE,         CND_NEVER,      U_IDLE,    1'b1};
      endcase
      return w;
   endfunction

   // entry point of each input function
   function automatic logic [UPC_W-1:0] dispatch(input logic [FUNC_W-1:0] func);
      logic [UPC_W-1:0] a;
      unique case (func)
         FUNC_START:      a = U_START;
         FUNC_PEER_REQ:   a = U_PREQ;
         FUNC_PEER_REPLY: a = U_PREP;
         FUNC_PEER_DONE:  a = U_PDONE;
         FUNC_RELEASE:    a = U_REL;
         default:         a = U_IDLE;
      endcase
      return a;
   endfunction

   // one bit per node id below the node count
   function automatic logic [SLOTS-1:0] peer_mask(input int nodes);
      logic [SLOTS-1:0] m;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = (i < nodes);
      end
      return m;
   endfunction

endpackage

// ===== rtl/mere_seq.sv =====
// microcode sequencer: step counter, control store and branch logic
`include "mutual_exclusion_request_engine_defines.svh"

module mere_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mere_pkg::FUNC_W-1:0]  func,
   input  logic                         out_free,
   input  mere_pkg::status_type         status,
   output mere_pkg::ctrl_type           ctrl,
   output logic                         busy
);

   logic                        busy_ff, busy_in;
   logic [mere_pkg::UPC_W-1:0]  upc_ff, upc_in;
   mere_pkg::ucode_type         word;
   logic                        hold;
   logic                        taken;
   logic                        advance;
   logic                        end_step;

   // current control word
   assign word = mere_pkg::ucode_rom(upc_ff);

   // branch condition
   always_comb begin
      unique case (word.cond)
         mere_pkg::CND_NEVER:      taken = 1'b0;
         mere_pkg::CND_ALWAYS:     taken = 1'b1;
         mere_pkg::CND_REQUESTING: taken = status.requesting;
         mere_pkg::CND_BAD_SENDER: taken = status.bad_sender;
         mere_pkg::CND_DEFER:      taken = status.defer;
         mere_pkg::CND_DEF_EMPTY:  taken = status.def_empty;
         mere_pkg::CND_WALK_MORE:  taken = status.walk_more;
         default:                  taken = 1'b0;
      endcase
   end

   // an emitting step waits for a free output register
   assign hold     = busy_ff && (word.emit != mere_pkg::EM_OFF) && !out_free;
   assign advance  = busy_ff && !hold;
   assign end_step = advance && !taken && word.fin;

   assign ctrl.act  = advance ? word.act  : mere_pkg::ACT_NONE;
   assign ctrl.emit = advance ? word.emit : mere_pkg::EM_OFF;
   assign ctrl.last = !taken && word.fin;
   assign busy      = busy_ff;

   // next step
   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (start) begin
         busy_in = 1'b1;
         upc_in  = mere_pkg::dispatch(func);
      end else if (advance) begin
         if (end_step) begin
            busy_in = 1'b0;
         end else if (taken) begin
            upc_in = word.target;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= mere_pkg::U_IDLE;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   // checks
   `MERE_ASSERT_NEXT(a_start_busy, start, busy_ff, "accepted transaction did not start the program")
   `MERE_ASSERT_NEXT(a_hold_upc, hold, $stable(upc_ff) && busy_ff, "step moved while output was full")
   `MERE_ASSERT_NOW(a_no_start_busy, start, !busy_ff, "transaction accepted while program running")

endmodule

// ===== rtl/mere_dp.sv =====
// datapath: peer masks, request state, latched transaction and result fields
`include "mutual_exclusion_request_engine_defines.svh"

module mere_dp #(
   parameter int MAX_NODES = mere_pkg::MAX_NODES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [mere_pkg::ID_W-1:0]        sender_id,
   input  logic [mere_pkg::TIME_W-1:0]      msg_time,
   input  logic [mere_pkg::TIME_W-1:0]      local_clock,
   input  logic                             csr_we,
   input  logic [mere_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mere_pkg::CSR_DATA_W-1:0]  csr_data,
   input  mere_pkg::ctrl_type               ctrl,
   output mere_pkg::status_type             status,
   output mere_pkg::item_type               item
);

   localparam logic [mere_pkg::SLOTS-1:0] PEER_MASK = mere_pkg::peer_mask(MAX_NODES);

   logic [mere_pkg::ID_W-1:0]   my_id_ff, my_id_in;
   logic [mere_pkg::SLOTS-1:0]  present_ff, present_in;
   logic [mere_pkg::SLOTS-1:0]  replied_ff, replied_in;
   logic [mere_pkg::SLOTS-1:0]  deferred_ff, deferred_in;
   logic [mere_pkg::TIME_W-1:0] own_time_ff, own_time_in;
   logic                        requesting_ff, requesting_in;
   logic [mere_pkg::ID_W-1:0]   sender_ff;
   logic [mere_pkg::TIME_W-1:0] mtime_ff;
   logic [mere_pkg::TIME_W-1:0] stamp_ff;
   logic [mere_pkg::SLOTS-1:0]  sbit;
   logic [mere_pkg::SLOTS-1:0]  need;
   logic [mere_pkg::SLOTS-1:0]  low_bit;
   logic [mere_pkg::ID_W-1:0]   low_idx;
   logic                        ours_later;

   assign sbit = mere_pkg::SLOTS'(1) << sender_ff;

   // lowest deferred peer
   always_comb begin
      low_idx = '0;
      for (int i = mere_pkg::SLOTS - 1; i >= 0; i--) begin
         if (deferred_ff[i]) begin
            low_idx = mere_pkg::ID_W'(i);
         end
      end
   end
   assign low_bit = mere_pkg::SLOTS'(1) << low_idx;

   // tie-break on (time, id)
   assign ours_later = (own_time_ff > mtime_ff) ||
                       ((own_time_ff == mtime_ff) && (my_id_ff > sender_ff));

   assign status.requesting = requesting_ff;
   assign status.bad_sender = (sender_ff == my_id_ff) || !PEER_MASK[sender_ff];
   assign status.defer      = requesting_ff && !ours_later;
   assign status.def_empty  = (deferred_ff == '0);
   assign status.walk_more  = ((deferred_ff & ~low_bit) != '0);

   // grant: every present peer but ourselves has replied
   assign need = present_ff & PEER_MASK & ~(mere_pkg::SLOTS'(1) << my_id_ff);
   assign item.granted = requesting_ff && ((need & ~replied_ff) == '0);
   assign item.last    = ctrl.last;

   // result fields
   always_comb begin
      unique case (ctrl.emit)
         mere_pkg::EM_MCAST: begin
            item.send_kind = mere_pkg::KIND_MCAST;
            item.dest_id   = '0;
            item.send_time = stamp_ff;
         end
         mere_pkg::EM_REPLY_SENDER: begin
            item.send_kind = mere_pkg::KIND_REPLY;
            item.dest_id   = sender_ff;
            item.send_time = stamp_ff;
         end
         mere_pkg::EM_REPLY_WALK: begin
            item.send_kind = mere_pkg::KIND_REPLY;
            item.dest_id   = low_idx;
            item.send_time = stamp_ff;
         end
         default: begin
            item.send_kind = mere_pkg::KIND_NONE;
            item.dest_id   = '0;
            item.send_time = '0;
         end
      endcase
   end

   // state updates from the control word and register writes
   always_comb begin
      my_id_in      = my_id_ff;
      present_in    = present_ff;
      replied_in    = replied_ff;
      deferred_in   = deferred_ff;
      own_time_in   = own_time_ff;
      requesting_in = requesting_ff;
      unique case (ctrl.act)
         mere_pkg::ACT_SET_REQ: begin
            requesting_in = 1'b1;
            own_time_in   = stamp_ff;
            replied_in    = '0;
         end
         mere_pkg::ACT_SET_DEFER: begin
            deferred_in = deferred_ff | sbit;
         end
         mere_pkg::ACT_MARK_REPLY: begin
            if (requesting_ff) begin
               replied_in = replied_ff | sbit;
            end
         end
         mere_pkg::ACT_DROP_PEER: begin
            present_in  = present_ff & ~sbit;
            replied_in  = replied_ff & ~sbit;
            deferred_in = deferred_ff & ~sbit;
         end
         mere_pkg::ACT_CLR_REQ: begin
            requesting_in = 1'b0;
            replied_in    = '0;
         end
         default: begin
         end
      endcase
      if (ctrl.emit == mere_pkg::EM_REPLY_WALK) begin
         deferred_in = deferred_ff & ~low_bit;
      end
      if (csr_we) begin
         unique case (csr_index)
            mere_pkg::CSR_MY_NODE_ID: my_id_in   = csr_data[mere_pkg::ID_W-1:0];
            mere_pkg::CSR_PEER_MASK:  present_in = csr_data[mere_pkg::SLOTS-1:0] & PEER_MASK;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff      <= '0;
         present_ff    <= '0;
         replied_ff    <= '0;
         deferred_ff   <= '0;
         own_time_ff   <= '0;
         requesting_ff <= 1'b0;
      end else begin
         my_id_ff      <= my_id_in;
         present_ff    <= present_in;
         replied_ff    <= replied_in;
         deferred_ff   <= deferred_in;
         own_time_ff   <= own_time_in;
         requesting_ff <= requesting_in;
      end
   end

   // latched transaction
   always_ff @(posedge clock) begin
      if (load) begin
         sender_ff <= sender_id;
         mtime_ff  <= msg_time;
         stamp_ff  <= local_clock + 1'b1;
      end
   end

   // checks
   `MERE_ASSERT_NOW(a_walk_nonempty, ctrl.emit == mere_pkg::EM_REPLY_WALK, deferred_ff != '0, "deferred walk with no deferred peer")
   `MERE_ASSERT_NEXT(a_mcast_requesting, ctrl.emit == mere_pkg::EM_MCAST, requesting_ff, "multicast sent while not requesting")
   `MERE_ASSERT_NEXT(a_release_clears, ctrl.act == mere_pkg::ACT_CLR_REQ, !requesting_ff && replied_ff == '0, "release left request state")

endmodule

// ===== rtl/mutual_exclusion_request_engine.sv =====
// top level of the mutual exclusion request engine
//
// One node's side of Ricart-Agrawala mutual exclusion. A transaction on the
// req_ channel carries one event (start, peer request, peer reply, peer done,
// release); the engine answers with one or more rsp_ transactions, the final
// one marked by rsp_last. Each carries the message to send and the grant
// status as seen after the event.
// The csr_ channel writes the node id (index 0) and the peer mask (index 1),
// which also reloads the present-peer set.
// A small microprogram runs each event, one step per cycle while rsp_stall
// does not hold it, on one transaction at a time: the input is accepted, then
// start takes 2 steps when already requesting and 3 otherwise, peer request 2
// to 4, peer reply and peer done 2 to 3, release 2 plus one for each deferred
// peer answered (3 when none), an unknown code 1. The next event is accepted
// the cycle after the last result is loaded into the output register.
// rsp_stall freezes the program at its next emitting step and holds the
// output register; req_stall is high while a program runs.
// Synchronous reset clears all peer masks, the request state and the node id.

module mutual_exclusion_request_engine #(
   parameter int MAX_NODES = mere_pkg::MAX_NODES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // event channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mere_pkg::FUNC_W-1:0]      req_func,
   input  logic [mere_pkg::ID_W-1:0]        req_sender_id,
   input  logic [mere_pkg::TIME_W-1:0]      req_msg_time,
   input  logic [mere_pkg::TIME_W-1:0]      req_local_clock,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mere_pkg::KIND_W-1:0]      rsp_send_kind,
   output logic [mere_pkg::ID_W-1:0]        rsp_dest_id,
   output logic [mere_pkg::TIME_W-1:0]      rsp_send_time,
   output logic                             rsp_granted,
   output logic                             rsp_last,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mere_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mere_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                  busy;
   logic                  start;
   logic                  out_free;
   mere_pkg::ctrl_type    ctrl;
   mere_pkg::status_type  status;
   mere_pkg::item_type    item;
   logic                  rsp_valid_ff, rsp_valid_in;
   mere_pkg::item_type    rsp_item_ff;

   // handshakes
   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign csr_ready = !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   mere_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .func     (req_func),
      .out_free (out_free),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   mere_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .load        (start),
      .sender_id   (req_sender_id),
      .msg_time    (req_msg_time),
      .local_clock (req_local_clock),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .ctrl        (ctrl),
      .status      (status),
      .item        (item)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit != mere_pkg::EM_OFF) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit != mere_pkg::EM_OFF) begin
         rsp_item_ff <= item;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_send_kind = rsp_item_ff.send_kind;
   assign rsp_dest_id   = rsp_item_ff.dest_id;
   assign rsp_send_time = rsp_item_ff.send_time;
   assign rsp_granted   = rsp_item_ff.granted;
   assign rsp_last      = rsp_item_ff.last;

endmodule
